// ===== design/assert_macros.svh =====
// assertion macros for the design files
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// overlapping implication, checked on the same edge
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// non-overlapping implication, consequent checked on the next edge
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== design/itfcp_pkg.sv =====
// types and constants for the text format code parser
// no dependencies
package itfcp_pkg;

  localparam int unsigned CP_W = 21;
  localparam int unsigned ACC_W = 7;
  localparam int unsigned COL_W = 4;

  // number of palette entries that a colour index may select
  localparam int unsigned PALETTE_SIZE = 16;
  localparam logic [ACC_W-1:0] PALETTE_LIMIT = ACC_W'(PALETTE_SIZE);

  // control code points
  localparam logic [CP_W-1:0] CP_BOLD      = 21'h02;
  localparam logic [CP_W-1:0] CP_COLOUR    = 21'h03;
  localparam logic [CP_W-1:0] CP_PLAIN     = 21'h0F;
  localparam logic [CP_W-1:0] CP_REVERSE   = 21'h16;
  localparam logic [CP_W-1:0] CP_ITALIC    = 21'h1D;
  localparam logic [CP_W-1:0] CP_UNDERLINE = 21'h1F;
  localparam logic [CP_W-1:0] CP_COMMA     = 21'h2C;
  localparam logic [CP_W-1:0] CP_DIGIT_0   = 21'h30;
  localparam logic [CP_W-1:0] CP_DIGIT_9   = 21'h39;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            end_of_line;
  } in_word_t;

  typedef struct packed {
    logic             has_char;
    logic [CP_W-1:0]  char_out;
    logic             bold;
    logic             italic;
    logic             underline;
    logic             fore_set;
    logic [COL_W-1:0] fore_index;
    logic             back_set;
    logic [COL_W-1:0] back_index;
    logic             line_done;
  } out_word_t;

endpackage

// ===== design/irc_text_format_code_parser.sv =====
// top level of the chat text format code parser: attribute state and result register
// depends on itfcp_pkg and assert_macros.svh
//
//   channel | direction | handshake                 | payload
//   in      | input     | in_valid_i / in_ready_o   | in_data_i  (in_word_t)
//   out     | output    | out_valid_o / out_ready_i | out_data_o (out_word_t)
//
// one code point per cycle while not stalled; its result, if any, shows the next cycle
// the rate is set by the attribute update, a single pass between state and output register
// input is taken whenever the output register is empty or being drained the same cycle
// a stalled output holds the input off; items without a result still wait for that slot
// reset clears all attributes, colours and the colour code phase
`include "assert_macros.svh"

module irc_text_format_code_parser
  import itfcp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_data_o
);

  // colour code phase
  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_FG0  = 3'd1;
  localparam logic [2:0] PH_FG1  = 3'd2;
  localparam logic [2:0] PH_FG2  = 3'd3;
  localparam logic [2:0] PH_BG0  = 3'd4;
  localparam logic [2:0] PH_BG1  = 3'd5;

  logic             bold_q, bold_d;
  logic             italic_q, italic_d;
  logic             underline_q, underline_d;
  logic             fore_valid_q, fore_valid_d;
  logic [COL_W-1:0] fore_colour_q, fore_colour_d;
  logic             back_valid_q, back_valid_d;
  logic [COL_W-1:0] back_colour_q, back_colour_d;
  logic [2:0]       phase_q, phase_d;
  logic [ACC_W-1:0] fore_accum_q, fore_accum_d;
  logic [ACC_W-1:0] back_accum_q, back_accum_d;

  logic      out_valid_q;
  out_word_t out_data_q;

  logic            in_fire;
  logic [CP_W-1:0] cp;
  logic            eol;
  logic            digit;
  logic [3:0]      dval;
  logic            consumed;
  logic            emit;
  out_word_t       res;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign cp         = in_data_i.code_point;
  assign eol        = in_data_i.end_of_line;

  // next attribute state and result for the word at the input
  always_comb begin
    bold_d        = bold_q;
    italic_d      = italic_q;
    underline_d   = underline_q;
    fore_valid_d  = fore_valid_q;
    fore_colour_d = fore_colour_q;
    back_valid_d  = back_valid_q;
    back_colour_d = back_colour_q;
    phase_d       = phase_q;
    fore_accum_d  = fore_accum_q;
    back_accum_d  = back_accum_q;
    consumed      = 1'b0;
    emit          = 1'b0;
    digit         = cp inside {[CP_DIGIT_0:CP_DIGIT_9]};
    dval          = digit ? cp[3:0] : 4'd0;

    // colour code digits and comma
    case (phase_q)
      PH_FG0, PH_FG1, PH_FG2: begin
        if (digit && phase_q != PH_FG2) begin
          if (phase_q == PH_FG0) begin
            fore_accum_d = {3'b000, dval};
          end else begin
            fore_accum_d = ACC_W'((fore_accum_q << 3) + (fore_accum_q << 1)
                                  + {3'b000, dval});
          end
          phase_d  = phase_q + 3'd1;
          consumed = 1'b1;
        end else begin
          if (phase_q != PH_FG0 && fore_accum_d < PALETTE_LIMIT) begin
            fore_valid_d  = 1'b1;
            fore_colour_d = fore_accum_d[COL_W-1:0];
          end
          if (cp == CP_COMMA) begin
            phase_d      = PH_BG0;
            back_accum_d = '0;
            consumed     = 1'b1;
          end else begin
            phase_d = PH_IDLE;
          end
        end
      end
      PH_BG0: begin
        if (digit) begin
          back_accum_d = {3'b000, dval};
          phase_d      = PH_BG1;
          consumed     = 1'b1;
        end else begin
          phase_d = PH_IDLE;
        end
      end
      PH_BG1: begin
        if (digit) begin
          back_accum_d = ACC_W'((back_accum_q << 3) + (back_accum_q << 1)
                                + {3'b000, dval});
          consumed     = 1'b1;
        end
        if (back_accum_d < PALETTE_LIMIT) begin
          back_valid_d  = 1'b1;
          back_colour_d = back_accum_d[COL_W-1:0];
        end
        phase_d = PH_IDLE;
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase

    // control codes and printable characters
    if (!consumed) begin
      case (cp)
        CP_BOLD:      bold_d = !bold_d;
        CP_COLOUR: begin
          phase_d      = PH_FG0;
          fore_accum_d = '0;
        end
        CP_PLAIN: begin
          bold_d       = 1'b0;
          italic_d     = 1'b0;
          underline_d  = 1'b0;
          fore_valid_d = 1'b0;
          back_valid_d = 1'b0;
        end
        CP_REVERSE:   ;
        CP_ITALIC:    italic_d = !italic_d;
        CP_UNDERLINE: underline_d = !underline_d;
        default:      emit = 1'b1;
      endcase
    end

    // a colour code cut off by the line end still takes effect
    if (eol) begin
      if ((phase_d == PH_FG1 || phase_d == PH_FG2) && fore_accum_d < PALETTE_LIMIT) begin
        fore_valid_d  = 1'b1;
        fore_colour_d = fore_accum_d[COL_W-1:0];
      end else if (phase_d == PH_BG1 && back_accum_d < PALETTE_LIMIT) begin
        back_valid_d  = 1'b1;
        back_colour_d = back_accum_d[COL_W-1:0];
      end
      phase_d = PH_IDLE;
    end

    // result word from the updated attributes
    res.has_char   = emit;
    res.char_out   = emit ? cp : '0;
    res.bold       = bold_d;
    res.italic     = italic_d;
    res.underline  = underline_d;
    res.fore_set   = fore_valid_d;
    res.fore_index = fore_colour_d;
    res.back_set   = back_valid_d;
    res.back_index = back_colour_d;
    res.line_done  = eol;

    // everything starts over after the line end
    if (eol) begin
      bold_d        = 1'b0;
      italic_d      = 1'b0;
      underline_d   = 1'b0;
      fore_valid_d  = 1'b0;
      fore_colour_d = '0;
      back_valid_d  = 1'b0;
      back_colour_d = '0;
      phase_d       = PH_IDLE;
      fore_accum_d  = '0;
      back_accum_d  = '0;
    end
  end

  // attribute state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bold_q        <= 1'b0;
      italic_q      <= 1'b0;
      underline_q   <= 1'b0;
      fore_valid_q  <= 1'b0;
      fore_colour_q <= '0;
      back_valid_q  <= 1'b0;
      back_colour_q <= '0;
      phase_q       <= PH_IDLE;
      fore_accum_q  <= '0;
      back_accum_q  <= '0;
    end else if (in_fire) begin
      bold_q        <= bold_d;
      italic_q      <= italic_d;
      underline_q   <= underline_d;
      fore_valid_q  <= fore_valid_d;
      fore_colour_q <= fore_colour_d;
      back_valid_q  <= back_valid_d;
      back_colour_q <= back_colour_d;
      phase_q       <= phase_d;
      fore_accum_q  <= fore_accum_d;
      back_accum_q  <= back_accum_d;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire && (emit || eol)) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (in_fire && (emit || eol)) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // checks
  `ASSERT_NEXT(a_word_emits, clk_i, rst_ni, in_fire && (emit || eol), out_valid_q)
  `ASSERT_NEXT(a_line_clears, clk_i, rst_ni, in_fire && eol,
               phase_q == PH_IDLE && !bold_q && !italic_q && !underline_q &&
               !fore_valid_q && !back_valid_q)
  `ASSERT_IMPL(a_empty_is_line_end, clk_i, rst_ni, out_valid_q && !out_data_q.has_char,
               out_data_q.line_done && out_data_q.char_out == '0)

endmodule
